// ===== hdl/fpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_pkg
// Widths, constants and types shared by the fuzzy PD controller modules.
// ----------------------------------------------------------------------------
package fpd_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	localparam int LEVEL_W = 13;
	localparam int OUT_W   = 14;
	localparam int ADDR_W  = 3;

	// grade 0..8.0 in fixed point, rule sum full..2*full
	localparam int GRADE_W = FRAC_BITS + 4;
	localparam int SUM_W   = FRAC_BITS + 5;
	localparam int QBITS   = LEVEL_W;
	localparam int REM_W   = LEVEL_W + GRADE_W;
	localparam int EXT_W   = DATA_WIDTH + FRAC_BITS + 4;

	localparam logic [GRADE_W-1:0] FULL_GRADE  = GRADE_W'(8 << FRAC_BITS);
	localparam logic [EXT_W-1:0]   GRADE_SHIFT = EXT_W'(4 << FRAC_BITS);
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(4 << FRAC_BITS);

	localparam logic [0:0] REG_LEVEL = 1'b0;

	// one divider cell's worth of in-flight state
	typedef struct packed {
		logic [SUM_W-1:0] part;
		logic [QBITS-1:0] quo;
		logic [SUM_W-1:0] dvs;
		logic             neg;
	} div_t;

endpackage

// ===== hdl/fpd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_front
// Fuzzification, rule strengths and weighted numerator: three stages that
// load the first divider cell.
// ----------------------------------------------------------------------------
module fpd_front
	import fpd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic signed [DATA_WIDTH-1:0] error_sample,
	input  logic signed [DATA_WIDTH-1:0] error_change,
	input  logic        [LEVEL_W-1:0]    level,
	output logic                         out_vld,
	output div_t                         out_div
);

	localparam logic signed [EXT_W-1:0] FULL_EXT = EXT_W'(FULL_GRADE);

	logic                     vld_s1, vld_s2, vld_s3;
	logic [GRADE_W-1:0]       pe_s1, pc_s1;
	logic signed [GRADE_W:0]  diff_s2;
	logic [SUM_W-1:0]         sum_s2;
	div_t                     div_s3;

	logic signed [EXT_W-1:0]  ge_raw, gc_raw;
	logic [GRADE_W-1:0]       pe_d, pc_d, ne, nc;
	logic [GRADE_W-1:0]       r_pp, r_pn, r_np, r_nn;
	logic signed [GRADE_W:0]  diff_neg;
	logic [GRADE_W-1:0]       diff_mag;
	logic [REM_W-1:0]         prod;

	always_comb begin
		ge_raw = EXT_W'(error_sample) + $signed(GRADE_SHIFT);
		gc_raw = EXT_W'(error_change) + $signed(GRADE_SHIFT);
		if (ge_raw < 0) begin
			pe_d = '0;
		end else if (ge_raw > FULL_EXT) begin
			pe_d = FULL_GRADE;
		end else begin
			pe_d = ge_raw[GRADE_W-1:0];
		end
		if (gc_raw < 0) begin
			pc_d = '0;
		end else if (gc_raw > FULL_EXT) begin
			pc_d = FULL_GRADE;
		end else begin
			pc_d = gc_raw[GRADE_W-1:0];
		end
	end

	always_comb begin
		ne   = FULL_GRADE - pe_s1;
		nc   = FULL_GRADE - pc_s1;
		r_pp = (pe_s1 < pc_s1) ? pe_s1 : pc_s1;
		r_pn = (pe_s1 < nc) ? pe_s1 : nc;
		r_np = (ne < pc_s1) ? ne : pc_s1;
		r_nn = (ne < nc) ? ne : nc;
	end

	always_comb begin
		diff_neg = -diff_s2;
		diff_mag = diff_s2[GRADE_W] ? diff_neg[GRADE_W-1:0] : diff_s2[GRADE_W-1:0];
		prod     = level * diff_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pe_s1   <= pe_d;
		pc_s1   <= pc_d;
		diff_s2 <= $signed({1'b0, r_pp}) - $signed({1'b0, r_nn});
		sum_s2  <= SUM_W'(r_pp) + SUM_W'(r_pn) + SUM_W'(r_np) + SUM_W'(r_nn);
		// quotient fits QBITS, so the upper product bits start below the divisor
		div_s3.part <= SUM_W'(prod[REM_W-1:QBITS]);
		div_s3.quo  <= prod[QBITS-1:0];
		div_s3.dvs  <= sum_s2;
		div_s3.neg  <= diff_s2[GRADE_W];
	end

	assign out_vld = vld_s3;
	assign out_div = div_s3;

endmodule

// ===== hdl/fpd_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_div_cell
// One restoring division step: shift in a dividend bit, trial subtract,
// shift the quotient bit in, hand the word to the next cell.
// ----------------------------------------------------------------------------
module fpd_div_cell
	import fpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  div_t in_div,
	output logic out_vld,
	output div_t out_div
);

	logic             vld_q;
	div_t             div_q;
	logic [SUM_W:0]   trial;
	logic [SUM_W:0]   rest;
	logic             take;

	always_comb begin
		trial = {in_div.part, in_div.quo[QBITS-1]};
		rest  = trial - {1'b0, in_div.dvs};
		take  = (trial >= {1'b0, in_div.dvs});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		div_q.part <= take ? rest[SUM_W-1:0] : trial[SUM_W-1:0];
		div_q.quo  <= {in_div.quo[QBITS-2:0], take};
		div_q.dvs  <= in_div.dvs;
		div_q.neg  <= in_div.neg;
	end

	assign out_vld = vld_q;
	assign out_div = div_q;

endmodule

// ===== hdl/fuzzy_pd_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_pd_controller
// Four-rule Sugeno fuzzy PD controller: u = level*(R_PP-R_NN)/sum(R).
//
//   channel   signals                                 handshake
//   request   start, busy, error_sample, error_change  start & !busy
//   result    done, drive_value                        done, one cycle
//   config    psel, penable, pwrite, paddr, pwdata     APB, pready tied high
//
// A request is taken every cycle; busy stays low. Each result passes
// through three front stages, one quotient bit per cell in the divider
// cell row, and one output register. Reset clears the pipeline valid
// bits and loads level 4.0. The receiver cannot stall; results leave
// in request order.
// ----------------------------------------------------------------------------
module fuzzy_pd_controller
	import fpd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] error_sample,
	input  logic signed [DATA_WIDTH-1:0] error_change,
	output logic                         done,
	output logic signed [OUT_W-1:0]      drive_value,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [LEVEL_W-1:0]       level_q;
	logic                     done_q;
	logic signed [OUT_W-1:0]  drive_q;

	logic                     vld_chain [QBITS+1];
	div_t                     div_chain [QBITS+1];
	logic [OUT_W-1:0]         quo_ext;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_LEVEL)) begin
			level_q <= pwdata[LEVEL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LEVEL) begin
			prdata = 32'(level_q);
		end
	end

	fpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (start),
		.error_sample (error_sample),
		.error_change (error_change),
		.level        (level_q),
		.out_vld      (vld_chain[0]),
		.out_div      (div_chain[0])
	);

	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		fpd_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld_chain[i]),
			.in_div  (div_chain[i]),
			.out_vld (vld_chain[i+1]),
			.out_div (div_chain[i+1])
		);
	end

	// apply sign after the magnitude divide: truncates toward zero
	assign quo_ext = OUT_W'(div_chain[QBITS].quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_chain[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		drive_q <= div_chain[QBITS].neg ? -$signed(quo_ext) : $signed(quo_ext);
	end

	assign done        = done_q;
	assign drive_value = drive_q;

endmodule
